FILE: hw/rtl/gete_pkg.sv
// ----------------------------------------------------------------------------
// gete_pkg
// Shared types and codes for the graph edge table engine: request and
// result transactions, action and status codes, sequencer states.
// ----------------------------------------------------------------------------
package gete_pkg;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] node_a;
        logic [31:0] node_b;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] answer;
        logic [6:0] nodes_held;
        logic [8:0] edges_held;
    } rsp_t;

    localparam logic [2:0] ACT_ADD_NODE = 3'd0;
    localparam logic [2:0] ACT_ADD_EDGE = 3'd1;
    localparam logic [2:0] ACT_DEL_NODE = 3'd2;
    localparam logic [2:0] ACT_DEL_EDGE = 3'd3;
    localparam logic [2:0] ACT_TST_EDGE = 3'd4;
    localparam logic [2:0] ACT_DEGREE   = 3'd5;
    localparam logic [2:0] ACT_MAX_DEG  = 3'd6;
    localparam logic [2:0] ACT_CLEAR    = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECT   = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_NSCAN,
        S_ESCAN,
        S_MXN,
        S_MXW,
        S_FIN,
        S_WR2
    } state_t;

endpackage

FILE: hw/rtl/gete_ram.sv
// ----------------------------------------------------------------------------
// gete_ram
// Simple dual-port table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gete_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 33,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/graph_edge_table_engine.sv
// Add node scans the node table; add edge and remove node scan the node table and then
// the edge table, add edge storing a second new endpoint in a further state; remove edge,
// test edge and degree scan the edge table; max degree scans it once per stored node;
// clear sweeps both tables. One transaction at a time.
// After reset the clear sweep runs once; busy stays high for its length.
// The result strobe done lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// graph_edge_table_engine
// Node and undirected edge tables in two memories, scanned entry by entry
// by a sequencer that reads, evaluates and writes back.
// ----------------------------------------------------------------------------
module graph_edge_table_engine
    import gete_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256,
    parameter int ID_BITS   = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam int MAXD = (MAX_NODES > MAX_EDGES) ? MAX_NODES : MAX_EDGES;
    localparam int CW   = $clog2(MAXD + 1);
    localparam int NAW  = $clog2(MAX_NODES);
    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int NC   = $clog2(MAX_NODES + 1);
    localparam int EC   = $clog2(MAX_EDGES + 1);
    localparam int NW   = ID_BITS + 1;
    localparam int EW   = 2 * ID_BITS + 1;

    state_t state_reg, state_next;
    logic [2:0]         act_reg, act_next;
    logic [ID_BITS-1:0] a_reg, a_next;
    logic [ID_BITS-1:0] b_reg, b_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      pa_reg, pa_next;
    logic               pv_reg, pv_next;
    logic [NC-1:0]      n_reg, n_next;
    logic [NC-1:0]      ntot_reg, ntot_next;
    logic [EC-1:0]      etot_reg, etot_next;
    logic [EC-1:0]      deg_reg, deg_next;
    logic [EC-1:0]      max_reg, max_next;
    logic               fa_reg, fa_next;
    logic               fb_reg, fb_next;
    logic               f1_reg, f1_next;
    logic               f2_reg, f2_next;
    logic [NAW-1:0]     ia_reg, ia_next;
    logic [NAW-1:0]     free1_reg, free1_next;
    logic [NAW-1:0]     free2_reg, free2_next;
    logic               em_reg, em_next;
    logic [EAW-1:0]     eidx_reg, eidx_next;
    logic               ef_reg, ef_next;
    logic [EAW-1:0]     efree_reg, efree_next;
    logic               crsp_reg, crsp_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;

    logic           nwe, ewe;
    logic [NAW-1:0] nwa, nra;
    logic [EAW-1:0] ewa, era;
    logic [NW-1:0]  nwd, nrd;
    logic [EW-1:0]  ewd, erd;

    logic               issue;
    logic [ID_BITS-1:0] nid, ex, ey;
    logic [NC:0]        need_sum;

    gete_ram #(.DEPTH(MAX_NODES), .WIDTH(NW), .AW(NAW)) u_node_ram (
        .clk   (clk),
        .we    (nwe),
        .waddr (nwa),
        .wdata (nwd),
        .raddr (nra),
        .rdata (nrd)
    );

    gete_ram #(.DEPTH(MAX_EDGES), .WIDTH(EW), .AW(EAW)) u_edge_ram (
        .clk   (clk),
        .we    (ewe),
        .waddr (ewa),
        .wdata (ewd),
        .raddr (era),
        .rdata (erd)
    );

    assign nid = nrd[ID_BITS-1:0];
    assign ex  = erd[2*ID_BITS-1:ID_BITS];
    assign ey  = erd[ID_BITS-1:0];
    assign nra = (state_reg == S_MXN) ? n_reg[NAW-1:0] : cnt_reg[NAW-1:0];
    assign era = cnt_reg[EAW-1:0];

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            pv_reg    <= 1'b0;
            ntot_reg  <= '0;
            etot_reg  <= '0;
            crsp_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pv_reg    <= pv_next;
            ntot_reg  <= ntot_next;
            etot_reg  <= etot_next;
            crsp_reg  <= crsp_next;
            done_reg  <= done_next;
        end
    end

    // payload and scan bookkeeping
    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        pa_reg    <= pa_next;
        n_reg     <= n_next;
        deg_reg   <= deg_next;
        max_reg   <= max_next;
        fa_reg    <= fa_next;
        fb_reg    <= fb_next;
        f1_reg    <= f1_next;
        f2_reg    <= f2_next;
        ia_reg    <= ia_next;
        free1_reg <= free1_next;
        free2_reg <= free2_next;
        em_reg    <= em_next;
        eidx_reg  <= eidx_next;
        ef_reg    <= ef_next;
        efree_reg <= efree_next;
        rsp_reg   <= rsp_next;
    end

    // sequencer: next state, memory writes and result
    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cnt_next   = cnt_reg;
        pa_next    = pa_reg;
        pv_next    = 1'b0;
        n_next     = n_reg;
        ntot_next  = ntot_reg;
        etot_next  = etot_reg;
        deg_next   = deg_reg;
        max_next   = max_reg;
        fa_next    = fa_reg;
        fb_next    = fb_reg;
        f1_next    = f1_reg;
        f2_next    = f2_reg;
        ia_next    = ia_reg;
        free1_next = free1_reg;
        free2_next = free2_reg;
        em_next    = em_reg;
        eidx_next  = eidx_reg;
        ef_next    = ef_reg;
        efree_next = efree_reg;
        crsp_next  = crsp_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        nwe        = 1'b0;
        nwa        = cnt_reg[NAW-1:0];
        nwd        = '0;
        ewe        = 1'b0;
        ewa        = cnt_reg[EAW-1:0];
        ewd        = '0;
        issue      = 1'b0;
        need_sum   = (NC+1)'(ntot_reg) + (NC+1)'(!fa_reg) + (NC+1)'(!fb_reg);

        unique case (state_reg)
            // sweep both tables invalid
            S_CLR:
            begin
                if (cnt_reg == CW'(MAXD))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                    if (crsp_reg)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{ST_OK, 9'd0, 7'(ntot_reg), 9'(etot_reg)};
                    end
                    crsp_next = 1'b0;
                end
                else
                begin
                    nwe      = cnt_reg < CW'(MAX_NODES);
                    ewe      = cnt_reg < CW'(MAX_EDGES);
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // take a transaction and pick the first pass
            S_IDLE:
            begin
                if (start)
                begin
                    act_next = req.action;
                    a_next   = ID_BITS'(req.node_a);
                    b_next   = ID_BITS'(req.node_b);
                    cnt_next = '0;
                    n_next   = '0;
                    deg_next = '0;
                    max_next = '0;
                    fa_next  = 1'b0;
                    fb_next  = 1'b0;
                    f1_next  = 1'b0;
                    f2_next  = 1'b0;
                    em_next  = 1'b0;
                    ef_next  = 1'b0;
                    case (req.action) inside
                        ACT_ADD_NODE, ACT_ADD_EDGE, ACT_DEL_NODE: state_next = S_NSCAN;
                        ACT_DEL_EDGE, ACT_TST_EDGE, ACT_DEGREE:   state_next = S_ESCAN;
                        ACT_MAX_DEG:                              state_next = S_MXN;
                        default:
                        begin
                            ntot_next  = '0;
                            etot_next  = '0;
                            crsp_next  = 1'b1;
                            state_next = S_CLR;
                        end
                    endcase
                end
            end

            // scan node table: find endpoints and two free slots
            S_NSCAN:
            begin
                issue   = cnt_reg < CW'(MAX_NODES);
                pv_next = issue;
                pa_next = cnt_reg;
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (pv_reg)
                begin
                    if (nrd[ID_BITS])
                    begin
                        if (nid == a_reg && !fa_reg)
                        begin
                            fa_next = 1'b1;
                            ia_next = pa_reg[NAW-1:0];
                        end
                        if (nid == b_reg)
                        begin
                            fb_next = 1'b1;
                        end
                    end
                    else if (!f1_reg)
                    begin
                        f1_next    = 1'b1;
                        free1_next = pa_reg[NAW-1:0];
                    end
                    else if (!f2_reg)
                    begin
                        f2_next    = 1'b1;
                        free2_next = pa_reg[NAW-1:0];
                    end
                end
                if (!issue && !pv_reg)
                begin
                    cnt_next   = '0;
                    state_next = (act_reg == ACT_ADD_NODE) ? S_FIN : S_ESCAN;
                end
            end

            // scan edge table: match, free slot, degree; drop edges of a removed node
            S_ESCAN:
            begin
                issue   = cnt_reg < CW'(MAX_EDGES);
                pv_next = issue;
                pa_next = cnt_reg;
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (pv_reg)
                begin
                    if (erd[2*ID_BITS])
                    begin
                        if (((ex == a_reg && ey == b_reg) || (ex == b_reg && ey == a_reg))
                            && !em_reg)
                        begin
                            em_next   = 1'b1;
                            eidx_next = pa_reg[EAW-1:0];
                        end
                        if (ex == a_reg || ey == a_reg)
                        begin
                            deg_next = deg_reg + 1'b1;
                            if (act_reg == ACT_DEL_NODE && fa_reg)
                            begin
                                ewe = 1'b1;
                                ewa = pa_reg[EAW-1:0];
                            end
                        end
                    end
                    else if (!ef_reg)
                    begin
                        ef_next    = 1'b1;
                        efree_next = pa_reg[EAW-1:0];
                    end
                end
                if (!issue && !pv_reg)
                begin
                    cnt_next = '0;
                    if (act_reg == ACT_MAX_DEG)
                    begin
                        if (deg_reg > max_reg)
                        begin
                            max_next = deg_reg;
                        end
                        n_next     = n_reg + 1'b1;
                        state_next = S_MXN;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            // issue the read of the next node for the maximum
            S_MXN:
            begin
                if (n_reg == NC'(MAX_NODES))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_MXW;
                end
            end

            // count the degree of a stored node, skip an empty slot
            S_MXW:
            begin
                if (nrd[ID_BITS])
                begin
                    a_next     = nid;
                    b_next     = nid;
                    deg_next   = '0;
                    cnt_next   = '0;
                    state_next = S_ESCAN;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = S_MXN;
                end
            end

            // commit the update and form the result
            S_FIN:
            begin
                rsp_next.status = ST_OK;
                rsp_next.answer = '0;
                state_next      = S_IDLE;
                done_next       = 1'b1;
                case (act_reg)
                    ACT_ADD_NODE:
                    begin
                        if (fa_reg)
                        begin
                            rsp_next.status = ST_REJECT;
                        end
                        else if (ntot_reg >= NC'(MAX_NODES))
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            nwe       = 1'b1;
                            nwa       = free1_reg;
                            nwd       = {1'b1, a_reg};
                            ntot_next = ntot_reg + 1'b1;
                        end
                    end
                    ACT_ADD_EDGE:
                    begin
                        if (a_reg == b_reg || em_reg)
                        begin
                            rsp_next.status = ST_REJECT;
                        end
                        else if (etot_reg >= EC'(MAX_EDGES)
                                 || need_sum > (NC+1)'(MAX_NODES))
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            ewe       = 1'b1;
                            ewa       = efree_reg;
                            ewd       = {1'b1, a_reg, b_reg};
                            etot_next = etot_reg + 1'b1;
                            ntot_next = NC'(need_sum);
                            if (!fa_reg)
                            begin
                                nwe = 1'b1;
                                nwa = free1_reg;
                                nwd = {1'b1, a_reg};
                            end
                            if (!fb_reg)
                            begin
                                done_next  = 1'b0;
                                state_next = S_WR2;
                            end
                        end
                    end
                    ACT_DEL_NODE:
                    begin
                        if (!fa_reg)
                        begin
                            rsp_next.status = ST_NOTFOUND;
                        end
                        else
                        begin
                            nwe       = 1'b1;
                            nwa       = ia_reg;
                            ntot_next = ntot_reg - 1'b1;
                            etot_next = etot_reg - deg_reg;
                        end
                    end
                    ACT_DEL_EDGE:
                    begin
                        if (!em_reg)
                        begin
                            rsp_next.status = ST_NOTFOUND;
                        end
                        else
                        begin
                            ewe       = 1'b1;
                            ewa       = eidx_reg;
                            etot_next = etot_reg - 1'b1;
                        end
                    end
                    ACT_TST_EDGE:
                    begin
                        rsp_next.answer = {8'd0, (a_reg != b_reg) && em_reg};
                    end
                    ACT_DEGREE:
                    begin
                        rsp_next.answer = 9'(deg_reg);
                        if (deg_reg == '0)
                        begin
                            rsp_next.status = ST_NOTFOUND;
                        end
                    end
                    default:
                    begin
                        rsp_next.answer = 9'(max_reg);
                    end
                endcase
                rsp_next.nodes_held = 7'(ntot_next);
                rsp_next.edges_held = 9'(etot_next);
            end

            // store the second new endpoint
            S_WR2:
            begin
                nwe        = 1'b1;
                nwa        = fa_reg ? free1_reg : free2_reg;
                nwd        = {1'b1, b_reg};
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start work");

    a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ntot_reg <= NC'(MAX_NODES))
        else $error("node count above table size");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        etot_reg <= EC'(MAX_EDGES))
        else $error("edge count above table size");

endmodule

FILE: tb/sv/graph_edge_table_engine_tb.sv
// ----------------------------------------------------------------------------
// graph_edge_table_engine_tb
// Self-checking bench: a queue-fed driver sends graph requests in bursts, a
// local table model predicts each result, and a monitor compares every
// result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module graph_edge_table_engine_tb;
    import gete_pkg::*;

    localparam int NODE_CAP  = 64;
    localparam int EDGE_CAP  = 256;
    localparam int POOL_SIZE = 80;
    localparam int IDLE_LIMIT = 100000;

    typedef struct {
        req_t r;
        bit   hold;
    } pending_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    graph_edge_table_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // Shadow copy of the node and edge tables
    bit          node_used [NODE_CAP];
    logic [31:0] node_id   [NODE_CAP];
    bit          edge_used [EDGE_CAP];
    logic [31:0] edge_lo   [EDGE_CAP];
    logic [31:0] edge_hi   [EDGE_CAP];
    int          node_count;
    int          edge_count;

    pending_t    request_queue[$];
    rsp_t        result_queue[$];
    logic [31:0] id_pool [POOL_SIZE];
    int          error_count;
    int          burst_left;
    int          gap_left;
    int          idle_cycles;
    bit          stim_done;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int lookup_node(logic [31:0] id);
        for (int i = 0; i < NODE_CAP; i++)
            if (node_used[i] && node_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int lookup_edge(logic [31:0] a, logic [31:0] b);
        for (int i = 0; i < EDGE_CAP; i++)
            if (edge_used[i] && ((edge_lo[i] == a && edge_hi[i] == b) ||
                                 (edge_lo[i] == b && edge_hi[i] == a)))
                return i;
        return -1;
    endfunction

    function automatic void store_node(logic [31:0] id);
        for (int i = 0; i < NODE_CAP; i++)
            if (!node_used[i])
            begin
                node_used[i] = 1'b1;
                node_id[i]   = id;
                node_count++;
                return;
            end
    endfunction

    function automatic int count_degree(logic [31:0] id);
        int d;
        d = 0;
        for (int i = 0; i < EDGE_CAP; i++)
            if (edge_used[i] && (edge_lo[i] == id || edge_hi[i] == id))
                d++;
        return d;
    endfunction

    // Apply one request to the shadow tables and return its result
    function automatic rsp_t apply_request(req_t r);
        rsp_t o;
        int   st;
        int   ans;
        int   n;
        int   need;
        int   d;
        st  = ST_OK;
        ans = 0;
        case (r.action)
            ACT_ADD_NODE:
                if (lookup_node(r.node_a) >= 0)
                    st = ST_REJECT;
                else if (node_count >= NODE_CAP)
                    st = ST_FULL;
                else
                    store_node(r.node_a);
            ACT_ADD_EDGE:
                if (r.node_a == r.node_b || lookup_edge(r.node_a, r.node_b) >= 0)
                    st = ST_REJECT;
                else
                begin
                    need = (lookup_node(r.node_a) < 0) + (lookup_node(r.node_b) < 0);
                    if (edge_count >= EDGE_CAP || node_count + need > NODE_CAP)
                        st = ST_FULL;
                    else
                    begin
                        for (int i = 0; i < EDGE_CAP; i++)
                            if (!edge_used[i])
                            begin
                                edge_used[i] = 1'b1;
                                edge_lo[i]   = r.node_a;
                                edge_hi[i]   = r.node_b;
                                edge_count++;
                                break;
                            end
                        if (lookup_node(r.node_a) < 0)
                            store_node(r.node_a);
                        if (lookup_node(r.node_b) < 0)
                            store_node(r.node_b);
                    end
                end
            ACT_DEL_NODE:
            begin
                n = lookup_node(r.node_a);
                if (n < 0)
                    st = ST_NOTFOUND;
                else
                begin
                    for (int i = 0; i < EDGE_CAP; i++)
                        if (edge_used[i] && (edge_lo[i] == r.node_a ||
                                             edge_hi[i] == r.node_a))
                        begin
                            edge_used[i] = 1'b0;
                            edge_count--;
                        end
                    node_used[n] = 1'b0;
                    node_count--;
                end
            end
            ACT_DEL_EDGE:
            begin
                n = lookup_edge(r.node_a, r.node_b);
                if (n < 0)
                    st = ST_NOTFOUND;
                else
                begin
                    edge_used[n] = 1'b0;
                    edge_count--;
                end
            end
            ACT_TST_EDGE:
                ans = (r.node_a != r.node_b && lookup_edge(r.node_a, r.node_b) >= 0);
            ACT_DEGREE:
            begin
                ans = count_degree(r.node_a);
                if (ans == 0)
                    st = ST_NOTFOUND;
            end
            ACT_MAX_DEG:
                for (int i = 0; i < NODE_CAP; i++)
                    if (node_used[i])
                    begin
                        d = count_degree(node_id[i]);
                        if (d > ans)
                            ans = d;
                    end
            default:
            begin
                for (int i = 0; i < NODE_CAP; i++)
                    node_used[i] = 1'b0;
                for (int i = 0; i < EDGE_CAP; i++)
                    edge_used[i] = 1'b0;
                node_count = 0;
                edge_count = 0;
            end
        endcase
        o.status     = st[1:0];
        o.answer     = ans[8:0];
        o.nodes_held = node_count[6:0];
        o.edges_held = edge_count[8:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic queue_request(logic [2:0] act, logic [31:0] a, logic [31:0] b,
                                 bit hold);
        pending_t p;
        p.r.action = act;
        p.r.node_a = a;
        p.r.node_b = b;
        p.hold     = hold;
        request_queue.insert(request_queue.size(), p);
    endtask

    function automatic logic [31:0] pick_id(int psize);
        if ($urandom_range(0, 15) == 0)
            return $urandom;
        return id_pool[$urandom_range(0, psize - 1)];
    endfunction

    function automatic logic [2:0] pick_action(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling)
            return (r < 10) ? ACT_ADD_NODE : (r < 95) ? ACT_ADD_EDGE : ACT_TST_EDGE;
        if (r < 20) return ACT_ADD_NODE;
        if (r < 50) return ACT_ADD_EDGE;
        if (r < 58) return ACT_DEL_NODE;
        if (r < 70) return ACT_DEL_EDGE;
        if (r < 82) return ACT_TST_EDGE;
        if (r < 94) return ACT_DEGREE;
        if (r < 97) return ACT_MAX_DEG;
        return ACT_CLEAR;
    endfunction

    // Driver: present the next queued transaction, honor gaps and holds
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            req        <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                result_queue.insert(result_queue.size(), apply_request(req));
                void'(request_queue.pop_front());
            end
            if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (request_queue.size() > 0 &&
                     !(request_queue[0].hold && (result_queue.size() > 0 || busy)))
            begin
                start <= 1'b1;
                req   <= request_queue[0].r;
                request_queue[0].hold = 1'b0;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check each result strobe against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (result_queue.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                if (rsp.status !== result_queue[0].status)
                    report_mismatch("status", rsp.status, result_queue[0].status);
                if (rsp.answer !== result_queue[0].answer)
                    report_mismatch("answer", rsp.answer, result_queue[0].answer);
                if (rsp.nodes_held !== result_queue[0].nodes_held)
                    report_mismatch("nodes_held", rsp.nodes_held,
                                    result_queue[0].nodes_held);
                if (rsp.edges_held !== result_queue[0].edges_held)
                    report_mismatch("edges_held", rsp.edges_held,
                                    result_queue[0].edges_held);
                void'(result_queue.pop_front());
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[graph_edge_table_engine] ERROR");
            $finish;
        end
    end

    initial
    begin
        int total;
        int seg_len;
        int psize;
        bit filling;
        error_count = 0;
        idle_cycles = 0;
        stim_done   = 1'b0;
        node_count  = 0;
        edge_count  = 0;
        for (int i = 0; i < NODE_CAP; i++)
            node_used[i] = 1'b0;
        for (int i = 0; i < EDGE_CAP; i++)
            edge_used[i] = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
            id_pool[i] = $urandom;
        id_pool[0] = 32'h0;
        id_pool[1] = 32'hFFFF_FFFF;

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extreme ids, every action, edge direction, rejects, misses
        queue_request(ACT_ADD_NODE, 32'h0, 32'h1234_5678, 1'b0);
        queue_request(ACT_ADD_NODE, 32'hFFFF_FFFF, 32'h0, 1'b0);
        queue_request(ACT_ADD_NODE, 32'h0, 32'hFFFF_FFFF, 1'b0);
        queue_request(ACT_ADD_EDGE, 32'h0, 32'hFFFF_FFFF, 1'b0);
        queue_request(ACT_ADD_EDGE, 32'hFFFF_FFFF, 32'h0, 1'b0);
        queue_request(ACT_ADD_EDGE, 32'h5555_AAAA, 32'h5555_AAAA, 1'b0);
        queue_request(ACT_TST_EDGE, 32'h0, 32'hFFFF_FFFF, 1'b0);
        queue_request(ACT_TST_EDGE, 32'hFFFF_FFFF, 32'h0, 1'b0);
        queue_request(ACT_TST_EDGE, 32'h0, 32'h0, 1'b0);
        queue_request(ACT_DEGREE, 32'h0, 32'hFFFF_FFFF, 1'b0);
        queue_request(ACT_DEGREE, 32'hAAAA_5555, 32'h0, 1'b0);
        queue_request(ACT_ADD_NODE, 32'h8000_0001, 32'h0, 1'b0);
        queue_request(ACT_DEGREE, 32'h8000_0001, 32'h0, 1'b0);
        queue_request(ACT_MAX_DEG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_request(ACT_ADD_EDGE, 32'h7FFF_FFFE, 32'h0000_0001, 1'b0);
        queue_request(ACT_DEL_EDGE, 32'hFFFF_FFFF, 32'h0, 1'b0);
        queue_request(ACT_DEL_EDGE, 32'hFFFF_FFFF, 32'h0, 1'b0);
        queue_request(ACT_DEL_NODE, 32'h1357_9BDF, 32'h0, 1'b0);
        queue_request(ACT_ADD_EDGE, 32'h0, 32'h7FFF_FFFE, 1'b0);
        queue_request(ACT_DEL_NODE, 32'h7FFF_FFFE, 32'hFFFF_FFFF, 1'b0);
        queue_request(ACT_MAX_DEG, 32'h0, 32'h0, 1'b0);
        queue_request(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_request(ACT_MAX_DEG, 32'h0, 32'h0, 1'b0);
        queue_request(ACT_DEGREE, 32'h0, 32'h0, 1'b0);
        total = 24;

        // Random: a long fill first to reach both full tables, then segments
        seg_len = 330;
        psize   = POOL_SIZE;
        filling = 1'b1;
        while (total < 720)
        begin
            for (int k = 0; k < seg_len; k++)
                queue_request(pick_action(filling), pick_id(psize), pick_id(psize),
                              (k == 0));
            total += seg_len;
            case ($urandom_range(0, 3))
                0: begin psize = 8;         filling = 1'b0; seg_len = 40; end
                1: begin psize = 24;        filling = 1'b0; seg_len = 50; end
                2: begin psize = POOL_SIZE; filling = 1'b1; seg_len = 60; end
                default:
                begin
                    psize = POOL_SIZE; filling = 1'b0; seg_len = 30;
                end
            endcase
        end

        while (request_queue.size() != 0 || result_queue.size() != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("[graph_edge_table_engine] OK");
        else
            $display("[graph_edge_table_engine] ERROR");
        $finish;
    end

endmodule
